### rtl/aabb_collider_table_assert.svh
// assertion macros for the collider table
// used by rtl modules that carry concurrent checks; expects i_clk and i_rst_n in scope
`ifndef AABB_COLLIDER_TABLE_ASSERT_SVH
`define AABB_COLLIDER_TABLE_ASSERT_SVH

// same-cycle implication
`define ACT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ACT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/act_pkg.sv
// shared types and constants of the collider table
// no dependencies; imported by act_ctrl, act_dp and aabb_collider_table
package act_pkg;

    localparam int SLOTS       = 16;
    localparam int COORD_BITS  = 16;
    localparam int MAX_RESULTS = 16;

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(MAX_RESULTS);
    localparam int DIM_W   = 15;
    localparam int KIND_W  = 2;
    localparam int REC_W   = 2 * COORD_BITS + 2 * DIM_W + KIND_W + 1;
    localparam int SUM_W   = ((COORD_BITS > DIM_W + 1) ? COORD_BITS : DIM_W + 1) + 1;
    localparam int IN_W    = 72;
    localparam int OUT_W   = 16;
    localparam int MTX_W   = 16;

    localparam logic [MTX_W-1:0] NOTIFY_RESET = 16'd3208;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_ERASE = 3'd1,
        OP_PURGE = 3'd2,
        OP_SCAN  = 3'd3,
        OP_CLEAR = 3'd4
    } t_op;

    typedef struct packed {
        logic accept;
        logic exec;
        logic base;
        logic step;
        logic done;
    } t_dp_cmd;

    typedef struct packed {
        logic is_scan;
        logic scan_ok;
        logic next_ok;
        logic last_slot;
        logic stall;
        logic out_free;
    } t_dp_st;

endpackage

### rtl/aabb_collider_table.sv
// top level of the collider table: stream ports, configuration register write port
// depends on act_pkg, act_ctrl, act_dp (which holds act_ram)
//
// One item is taken at a time; s_axis_tready is high only between items. Add, erase, purge,
// clear and unused op codes pass through the exec and done states to the done result. A scan
// of an occupied slot s passes through exec and base and then walks each higher slot, as the
// single read port of the rectangle ram reads the table one slot per cycle while no pair result
// is held up by downstream back-pressure. The result register lets the next item be taken
// while the done result is still waiting on m_axis.
module aabb_collider_table
    import act_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [MTX_W-1:0] i_cfg_wdata,     // notify_matrix
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // op[2:0] slot[6:3] rect_x[22:7] rect_y[38:23] rect_w[53:39] rect_h[68:54]
    // kind[70:69] has_listener[71]
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // first_slot[3:0] second_slot[7:4] notify_first[8] notify_second[9] table_full[10]
    output logic [OUT_W-1:0] m_axis_tdata,
    output logic             m_axis_tuser,    // pair_valid
    output logic             m_axis_tlast
);

    t_dp_cmd cmd;
    t_dp_st  st;

    act_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    act_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser),
        .o_m_tlast   (m_axis_tlast)
    );

endmodule

### rtl/act_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module act_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/act_ctrl.sv
// controller state machine of the collider table
// depends on act_pkg; drives act_dp through t_dp_cmd and reads t_dp_st
module act_ctrl
    import act_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_dp_st  i_st,
    output t_dp_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_BASE = 5'b00100,
        S_SCAN = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = (i_st.is_scan && i_st.scan_ok) ? S_BASE : S_DONE;
            end
            S_BASE: begin
                o_cmd.base = 1'b1;
                n_state    = i_st.next_ok ? S_SCAN : S_DONE;
            end
            S_SCAN: begin
                o_cmd.step = !i_st.stall;
                if (!i_st.stall && i_st.last_slot) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.done = i_st.out_free;
                if (i_st.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

endmodule

### rtl/act_dp.sv
// datapath of the collider table: slot flags, rectangle store, overlap test, result register
// depends on act_pkg, act_ram and aabb_collider_table_assert.svh
`include "aabb_collider_table_assert.svh"

module act_dp
    import act_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IN_W-1:0]  i_s_tdata,
    input  logic             i_cfg_we,
    input  logic [MTX_W-1:0] i_cfg_wdata,
    input  t_dp_cmd          i_cmd,
    output t_dp_st           o_st,
    input  logic             i_m_tready,
    output logic             o_m_tvalid,
    output logic [OUT_W-1:0] o_m_tdata,
    output logic             o_m_tuser,
    output logic             o_m_tlast
);

    // latched input item
    t_op                          r_op;
    logic [3:0]                   r_slot;
    logic [SLOT_W-1:0]            r_slot_idx;
    logic                         r_slot_ok;
    logic signed [COORD_BITS-1:0] r_x;
    logic signed [COORD_BITS-1:0] r_y;
    logic [DIM_W-1:0]             r_w;
    logic [DIM_W-1:0]             r_h;
    logic [KIND_W-1:0]            r_kind;
    logic                         r_lis;

    logic [SLOTS-1:0] r_occ, n_occ;
    logic [SLOTS-1:0] r_mark, n_mark;
    logic [MTX_W-1:0] r_matrix;

    // scanned slot
    logic signed [COORD_BITS-1:0] r_bx;
    logic signed [COORD_BITS-1:0] r_by;
    logic [DIM_W-1:0]             r_bw;
    logic [DIM_W-1:0]             r_bh;
    logic [KIND_W-1:0]            r_bkind;
    logic                         r_blis;

    logic [SLOT_W-1:0] r_k;
    logic [CNT_W-1:0]  r_npairs;
    logic [3:0]        r_res_first;
    logic              r_res_full;

    logic       r_out_valid, n_out_valid;
    logic       r_out_pv;
    logic [3:0] r_out_first;
    logic [3:0] r_out_second;
    logic       r_out_nf;
    logic       r_out_ns;
    logic       r_out_full;
    logic       r_out_last;

    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic              ram_we;
    logic [SLOT_W-1:0] ram_raddr;
    logic [REC_W-1:0]  ram_wdata;
    logic [REC_W-1:0]  ram_q;

    logic signed [COORD_BITS-1:0] q_x;
    logic signed [COORD_BITS-1:0] q_y;
    logic [DIM_W-1:0]             q_w;
    logic [DIM_W-1:0]             q_h;
    logic [KIND_W-1:0]            q_kind;
    logic                         q_lis;

    logic signed [SUM_W-1:0] px, pxe, py, pye, qx, qxe, qy, qye;
    logic overlap;
    logic hit;
    logic out_free;
    logic load_pair;

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_occ[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op       <= t_op'(i_s_tdata[2:0]);
            r_slot     <= i_s_tdata[6:3];
            r_slot_idx <= SLOT_W'(i_s_tdata[6:3]);
            r_slot_ok  <= (32'(i_s_tdata[6:3]) < SLOTS);
            r_x        <= COORD_BITS'($signed(i_s_tdata[22:7]));
            r_y        <= COORD_BITS'($signed(i_s_tdata[38:23]));
            r_w        <= i_s_tdata[53:39];
            r_h        <= i_s_tdata[68:54];
            r_kind     <= i_s_tdata[70:69];
            r_lis      <= i_s_tdata[71];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix <= NOTIFY_RESET;
        end else if (i_cfg_we) begin
            r_matrix <= i_cfg_wdata;
        end
    end

    always_comb begin
        n_occ  = r_occ;
        n_mark = r_mark;
        if (i_cmd.exec) begin
            unique case (r_op)
                OP_ADD: begin
                    if (free_found) begin
                        n_occ[free_idx]  = 1'b1;
                        n_mark[free_idx] = 1'b0;
                    end
                end
                OP_ERASE: begin
                    if (r_slot_ok && r_occ[r_slot_idx]) begin
                        n_mark[r_slot_idx] = 1'b1;
                    end
                end
                OP_PURGE: begin
                    n_occ  = r_occ & ~r_mark;
                    n_mark = '0;
                end
                OP_CLEAR: begin
                    n_occ  = '0;
                    n_mark = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ  <= '0;
            r_mark <= '0;
        end else begin
            r_occ  <= n_occ;
            r_mark <= n_mark;
        end
    end

    assign ram_we    = i_cmd.exec && (r_op == OP_ADD) && free_found;
    assign ram_wdata = {r_lis, r_kind, r_h, r_w, r_y, r_x};

    always_comb begin
        priority if (i_cmd.base) begin
            ram_raddr = r_slot_idx + SLOT_W'(1);
        end else if (i_cmd.step) begin
            ram_raddr = r_k + SLOT_W'(1);
        end else if (i_cmd.exec) begin
            ram_raddr = r_slot_idx;
        end else begin
            ram_raddr = r_k;
        end
    end

    act_ram #(
        .WIDTH (REC_W),
        .DEPTH (SLOTS)
    ) u_rect_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (free_idx),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    assign q_x    = ram_q[COORD_BITS-1:0];
    assign q_y    = ram_q[2*COORD_BITS-1:COORD_BITS];
    assign q_w    = ram_q[2*COORD_BITS+DIM_W-1:2*COORD_BITS];
    assign q_h    = ram_q[2*COORD_BITS+2*DIM_W-1:2*COORD_BITS+DIM_W];
    assign q_kind = ram_q[REC_W-2:REC_W-1-KIND_W];
    assign q_lis  = ram_q[REC_W-1];

    always_ff @(posedge i_clk) begin
        if (i_cmd.base) begin
            r_bx    <= q_x;
            r_by    <= q_y;
            r_bw    <= q_w;
            r_bh    <= q_h;
            r_bkind <= q_kind;
            r_blis  <= q_lis;
        end
    end

    // edge sums one bit wider than the coordinates, so that coordinate plus extent cannot overflow
    assign px  = SUM_W'(r_bx);
    assign pxe = SUM_W'(r_bx) + SUM_W'(r_bw);
    assign py  = SUM_W'(r_by);
    assign pye = SUM_W'(r_by) + SUM_W'(r_bh);
    assign qx  = SUM_W'(q_x);
    assign qxe = SUM_W'(q_x) + SUM_W'(q_w);
    assign qy  = SUM_W'(q_y);
    assign qye = SUM_W'(q_y) + SUM_W'(q_h);

    assign overlap = (px < qxe) && (pxe > qx) && (py < qye) && (pye > qy);
    assign hit     = r_occ[r_k] && overlap && (r_npairs < CNT_W'(MAX_RESULTS - 1));

    assign out_free  = !r_out_valid || i_m_tready;
    assign load_pair = i_cmd.step && hit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_npairs    <= '0;
            r_res_full  <= (r_op == OP_ADD) && !free_found;
            if ((r_op == OP_ADD) && free_found) begin
                r_res_first <= 4'(free_idx);
            end else if (r_op == OP_SCAN) begin
                r_res_first <= r_slot;
            end else begin
                r_res_first <= '0;
            end
        end else if (load_pair) begin
            r_npairs <= r_npairs + CNT_W'(1);
        end
        if (i_cmd.base) begin
            r_k <= r_slot_idx + SLOT_W'(1);
        end else if (i_cmd.step) begin
            r_k <= r_k + SLOT_W'(1);
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_pair || i_cmd.done) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_pair) begin
            r_out_pv     <= 1'b1;
            r_out_first  <= r_slot;
            r_out_second <= 4'(r_k);
            r_out_nf     <= r_matrix[{r_bkind, q_kind}] & r_blis;
            r_out_ns     <= r_matrix[{q_kind, r_bkind}] & q_lis;
            r_out_full   <= 1'b0;
            r_out_last   <= 1'b0;
        end else if (i_cmd.done) begin
            r_out_pv     <= 1'b0;
            r_out_first  <= r_res_first;
            r_out_second <= '0;
            r_out_nf     <= 1'b0;
            r_out_ns     <= 1'b0;
            r_out_full   <= r_res_full;
            r_out_last   <= 1'b1;
        end
    end

    assign o_st.is_scan   = (r_op == OP_SCAN);
    assign o_st.scan_ok   = r_slot_ok && r_occ[r_slot_idx];
    assign o_st.next_ok   = (r_slot_idx != SLOT_W'(SLOTS - 1));
    assign o_st.last_slot = (r_k == SLOT_W'(SLOTS - 1));
    assign o_st.stall     = hit && !out_free;
    assign o_st.out_free  = out_free;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_out_full, r_out_ns, r_out_nf, r_out_second, r_out_first};
    assign o_m_tuser  = r_out_pv;
    assign o_m_tlast  = r_out_last;

    `ACT_ASSERT_IMP(a_mark_on_occupied, 1'b1, (r_mark & ~r_occ) == '0, "delete mark on free slot")
    `ACT_ASSERT_NXT(a_add_takes_slot, i_cmd.exec && (r_op == OP_ADD) && free_found, $countones(r_occ) == $past($countones(r_occ)) + 1, "add did not take one slot")
    `ACT_ASSERT_NXT(a_pair_order, load_pair, r_out_valid && r_out_pv && (r_out_second > r_out_first), "pair result out of order")

endmodule

### tb/aabb_collider_table_test.sv
// self-checking testbench for aabb_collider_table: random and directed table ops over the
// stream ports, with an in-bench predictor of the table, the scan pairs and the notify flags
// depends on act_pkg and the aabb_collider_table rtl
module aabb_collider_table_test;
    import act_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int EDGE_W = 16;
    localparam int LONG_HOLD = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_PER_PHASE = 22;
    localparam int RANDOM_PHASES = 5;
    localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [2:0] OP_RSVD_MID = 3'd6;
    localparam logic [2:0] OP_RSVD_LAST = 3'd7;

    // same layout as s_axis_tdata: op, slot, rect_x, rect_y, rect_w, rect_h, kind,
    // has_listener from the lowest bit up
    typedef struct packed {
        logic              has_listener;
        logic [KIND_W-1:0] kind;
        logic [DIM_W-1:0]  rect_h;
        logic [DIM_W-1:0]  rect_w;
        logic [EDGE_W-1:0] rect_y;
        logic [EDGE_W-1:0] rect_x;
        logic [SLOT_W-1:0] slot;
        logic [2:0]        op;
    } t_table_cmd;

    typedef struct {
        logic              pair_valid;
        logic [SLOT_W-1:0] first_slot;
        logic [SLOT_W-1:0] second_slot;
        logic              notify_first;
        logic              notify_second;
        logic              table_full;
        logic              last;
    } t_table_result;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [MTX_W-1:0] i_cfg_wdata;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic             m_axis_tuser;
    logic             m_axis_tlast;

    // predictor state
    bit               slot_used[SLOTS];
    bit               slot_marked[SLOTS];
    int               left_st[SLOTS];
    int               top_st[SLOTS];
    int               wide_st[SLOTS];
    int               high_st[SLOTS];
    logic [KIND_W-1:0] kind_st[SLOTS];
    bit               listen_st[SLOTS];
    logic [MTX_W-1:0] notify_copy;

    t_table_cmd       cmd_queue[$];
    t_table_result    expected_results[$];
    int               cmds_queued = 0;
    int               cmds_accepted = 0;
    int               mismatch_count = 0;
    logic             in_fire = 1'b0;
    bit               calm_tail = 1'b0;
    int               hold_asked = 0;
    int               hold_taken = 0;
    int               send_gap = 0;
    int               stall_left = 0;

    aabb_collider_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit rects_overlap(int a, int b);
        return left_st[a] < left_st[b] + wide_st[b] && left_st[a] + wide_st[a] > left_st[b] &&
               top_st[a] < top_st[b] + high_st[b] && top_st[a] + high_st[a] > top_st[b];
    endfunction

    function automatic bit may_notify(int a, int b);
        return notify_copy[{kind_st[a], kind_st[b]}] && listen_st[a];
    endfunction

    function automatic void predict_table_op(t_table_cmd c);
        t_table_result done;
        t_table_result pair;
        int pairs;
        int base;
        bit placed;
        done = '{default: '0};
        done.last = 1'b1;
        pairs = 0;
        base = int'(c.slot);
        placed = 1'b0;
        unique case (c.op)
            OP_ADD: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!placed && !slot_used[i]) begin
                        slot_used[i] = 1'b1;
                        slot_marked[i] = 1'b0;
                        left_st[i] = int'($signed(c.rect_x));
                        top_st[i] = int'($signed(c.rect_y));
                        wide_st[i] = int'(c.rect_w);
                        high_st[i] = int'(c.rect_h);
                        kind_st[i] = c.kind;
                        listen_st[i] = c.has_listener;
                        done.first_slot = SLOT_W'(i);
                        placed = 1'b1;
                    end
                end
                done.table_full = !placed;
            end
            OP_ERASE: begin
                if (slot_used[c.slot])
                    slot_marked[c.slot] = 1'b1;
            end
            OP_PURGE: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_marked[i])
                        slot_used[i] = 1'b0;
                    slot_marked[i] = 1'b0;
                end
            end
            OP_SCAN: begin
                if (slot_used[c.slot]) begin
                    for (int k = base + 1; k < SLOTS; k++) begin
                        if (pairs < MAX_RESULTS - 1 && slot_used[k] &&
                            rects_overlap(base, k)) begin
                            pair = '{default: '0};
                            pair.pair_valid = 1'b1;
                            pair.first_slot = c.slot;
                            pair.second_slot = SLOT_W'(k);
                            pair.notify_first = may_notify(base, k);
                            pair.notify_second = may_notify(k, base);
                            expected_results.push_back(pair);
                            pairs++;
                        end
                    end
                end
                done.first_slot = c.slot;
            end
            OP_CLEAR: begin
                for (int i = 0; i < SLOTS; i++) begin
                    slot_used[i] = 1'b0;
                    slot_marked[i] = 1'b0;
                end
            end
            default: ;
        endcase
        expected_results.push_back(done);
    endfunction

    function automatic t_table_cmd make_cmd(logic [2:0] op, int slot, int x, int y,
                                            int w, int h, int kind, int lis);
        t_table_cmd c;
        c.op = op;
        c.slot = SLOT_W'(slot);
        c.rect_x = EDGE_W'(x);
        c.rect_y = EDGE_W'(y);
        c.rect_w = DIM_W'(w);
        c.rect_h = DIM_W'(h);
        c.kind = KIND_W'(kind);
        c.has_listener = 1'(lis);
        return c;
    endfunction

    function automatic t_table_cmd random_cmd();
        t_table_cmd c;
        logic [95:0] noise;
        int pick;
        noise = {$urandom, $urandom, $urandom};
        c = noise[IN_W-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 34)
            c.op = OP_ADD;
        else if (pick < 62)
            c.op = OP_SCAN;
        else if (pick < 78)
            c.op = OP_ERASE;
        else if (pick < 88)
            c.op = OP_PURGE;
        else if (pick < 92)
            c.op = OP_CLEAR;
        else
            c.op = 3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
        // mostly clustered rectangles so that scans find pairs
        if ($urandom_range(0, 7) != 0) begin
            c.rect_x = EDGE_W'($urandom_range(0, 600) - 300);
            c.rect_y = EDGE_W'($urandom_range(0, 600) - 300);
            c.rect_w = DIM_W'($urandom_range(0, 400));
            c.rect_h = DIM_W'($urandom_range(0, 400));
        end
        return c;
    endfunction

    task automatic queue_cmd(t_table_cmd c);
        cmd_queue.push_back(c);
        cmds_queued++;
    endtask

    task automatic check_field(string name, logic [SLOT_W-1:0] want, logic [SLOT_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (cmds_accepted != cmds_queued || expected_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_notify_matrix(logic [MTX_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (cmd_queue.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
                send_gap <= $urandom_range(0, 6);
                s_axis_tvalid <= 1'b0;
            end else begin
                s_axis_tdata <= cmd_queue.pop_front();
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_taken != hold_asked) begin
            hold_taken <= hold_asked;
            stall_left <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 6);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // predictor and result checker
    always @(posedge i_clk) begin
        t_table_cmd cmd;
        t_table_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_used[i] = 1'b0;
                slot_marked[i] = 1'b0;
            end
            notify_copy = NOTIFY_RESET;
            in_fire <= 1'b0;
        end else begin
            if (i_cfg_we)
                notify_copy = i_cfg_wdata;
            in_fire <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                cmd = s_axis_tdata;
                predict_table_op(cmd);
                cmds_accepted++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with nothing expected: tdata %h", m_axis_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("pair_valid", SLOT_W'(want.pair_valid), SLOT_W'(m_axis_tuser));
                    check_field("first_slot", want.first_slot, m_axis_tdata[3:0]);
                    check_field("second_slot", want.second_slot, m_axis_tdata[7:4]);
                    check_field("notify_first", SLOT_W'(want.notify_first),
                                SLOT_W'(m_axis_tdata[8]));
                    check_field("notify_second", SLOT_W'(want.notify_second),
                                SLOT_W'(m_axis_tdata[9]));
                    check_field("table_full", SLOT_W'(want.table_full),
                                SLOT_W'(m_axis_tdata[10]));
                    check_field("last", SLOT_W'(want.last), SLOT_W'(m_axis_tlast));
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        wait (i_rst_n === 1'b1);
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        logic [MTX_W-1:0] matrix;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, edge extremes, touching edges, marks and clear
        @(posedge i_clk);
        queue_cmd(make_cmd(OP_SCAN, 0, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_ERASE, 5, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_PURGE, 0, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_RSVD_FIRST, 3, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_RSVD_LAST, 0, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_ADD, 0, -32768, -32768, 32767, 32767, 3, 1));
        queue_cmd(make_cmd(OP_ADD, 0, 32767, 32767, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_ADD, 0, 0, 0, 1, 1, 1, 1));
        queue_cmd(make_cmd(OP_ADD, 0, -100, -100, 200, 200, 2, 1));
        queue_cmd(make_cmd(OP_ADD, 0, 1, 0, 5, 1, 1, 0));
        queue_cmd(make_cmd(OP_SCAN, 0, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_SCAN, 2, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_SCAN, 1, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_SCAN, 15, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_ERASE, 2, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_SCAN, 2, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_ADD, 0, -3, -3, 6, 6, 0, 1));
        queue_cmd(make_cmd(OP_ERASE, 9, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_PURGE, 0, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_ADD, 0, -50, -50, 10, 10, 3, 1));
        queue_cmd(make_cmd(OP_SCAN, 0, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_RSVD_MID, 0, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_SCAN, 0, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_ADD, 0, 10, 10, 10, 10, 2, 0));

        // full table of mutually overlapping rectangles, then purge and refill
        wait_drained();
        write_notify_matrix(MTX_W'($urandom));
        @(posedge i_clk);
        queue_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        repeat (SLOTS + 1)
            queue_cmd(make_cmd(OP_ADD, $urandom, $urandom_range(0, 100) - 50,
                               $urandom_range(0, 100) - 50, $urandom_range(200, 400),
                               $urandom_range(200, 400), $urandom, $urandom));
        queue_cmd(make_cmd(OP_SCAN, 0, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_SCAN, 7, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_ERASE, 3, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_ERASE, 9, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_PURGE, 0, 0, 0, 0, 0, 0, 0));
        repeat (3)
            queue_cmd(make_cmd(OP_ADD, 0, $urandom_range(0, 100) - 50,
                               $urandom_range(0, 100) - 50, $urandom_range(200, 400),
                               $urandom_range(200, 400), $urandom, $urandom));
        queue_cmd(make_cmd(OP_SCAN, 3, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_SCAN, 0, 0, 0, 0, 0, 0, 0));

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_drained();
            case (p)
                0: matrix = '0;
                2: matrix = '1;
                4: matrix = NOTIFY_RESET;
                default: matrix = MTX_W'($urandom);
            endcase
            write_notify_matrix(matrix);
            @(posedge i_clk);
            calm_tail = (p == RANDOM_PHASES - 1);
            if (p == 1)
                hold_asked++;
            repeat (RANDOM_PER_PHASE)
                queue_cmd(random_cmd());
        end

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/act_pkg.sv
rtl/act_ram.sv
rtl/act_ctrl.sv
rtl/act_dp.sv
rtl/aabb_collider_table.sv
tb/aabb_collider_table_test.sv
